### rtl/omrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omrs_pkg
// Shared constants, codes and types for the ordered multiset rank/select unit.
// ----------------------------------------------------------------------------
package omrs_pkg;

    localparam int CAPACITY   = 1024;
    localparam int COUNT_BITS = 16;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int USED_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W      = 32;
    localparam int CMD_W      = 3;
    localparam int ST_W       = 2;

    localparam logic [KEY_W-1:0]      SENTINEL     = 32'h3f3f3f3f;
    localparam logic [KEY_W-1:0]      SENTINEL_NEG = 32'hc0c0c0c1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};

    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_INSERT = 3'd0;
    localparam cmd_t CMD_REMOVE = 3'd1;
    localparam cmd_t CMD_RANK   = 3'd2;
    localparam cmd_t CMD_SELECT = 3'd3;
    localparam cmd_t CMD_PRED   = 3'd4;
    localparam cmd_t CMD_SUCC   = 3'd5;

    typedef logic [ST_W-1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_NONE = 2'd1;
    localparam status_t ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_DECIDE,
        S_SH_RD,
        S_SH_WR,
        S_UPDATE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0]     raddr;
        logic                  wen_key;
        logic                  wen_cnt;
        logic [ADDR_W-1:0]     waddr;
        logic [KEY_W-1:0]      wkey;
        logic [COUNT_BITS-1:0] wcnt;
    } mem_req_t;

    typedef struct packed {
        logic [KEY_W-1:0]      rkey;
        logic [COUNT_BITS-1:0] rcnt;
    } mem_rsp_t;

endpackage

### rtl/omrs_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omrs_store
// Key and copy-count memories: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module omrs_store (
    input  logic              clk,
    input  omrs_pkg::mem_req_t req,
    output omrs_pkg::mem_rsp_t rsp
);
    import omrs_pkg::*;

    logic [KEY_W-1:0]      key_mem [CAPACITY];
    logic [COUNT_BITS-1:0] cnt_mem [CAPACITY];
    mem_rsp_t              rsp_reg;

    always_ff @(posedge clk)
    begin
        if (req.wen_key)
        begin
            key_mem[req.waddr] <= req.wkey;
        end
        if (req.wen_cnt)
        begin
            cnt_mem[req.waddr] <= req.wcnt;
        end
        rsp_reg.rkey <= key_mem[req.raddr];
        rsp_reg.rcnt <= cnt_mem[req.raddr];
    end

    assign rsp = rsp_reg;

endmodule

### rtl/omrs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omrs_ctrl
// Command sequencer: scans the sorted table, answers queries, shifts entries.
// ----------------------------------------------------------------------------
module omrs_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  omrs_pkg::cmd_t                in_cmd,
    input  logic [omrs_pkg::KEY_W-1:0]    in_operand,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [omrs_pkg::KEY_W-1:0]    res_answer,
    output omrs_pkg::status_t             res_status,
    output omrs_pkg::mem_req_t            req,
    input  omrs_pkg::mem_rsp_t            rsp
);
    import omrs_pkg::*;

    state_t                state_reg, state_next;
    logic [USED_W-1:0]     used_reg, used_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;

    cmd_t                  cmd_reg, cmd_next;
    logic [KEY_W-1:0]      x_reg, x_next;
    logic [USED_W-1:0]     idx_reg, idx_next;
    logic [USED_W-1:0]     pos_reg, pos_next;
    logic [COUNT_BITS-1:0] sum_reg, sum_next;
    logic [COUNT_BITS-1:0] seen_reg, seen_next;
    logic [COUNT_BITS-1:0] pcnt_reg, pcnt_next;
    logic                  present_reg, present_next;
    logic [KEY_W-1:0]      pred_reg, pred_next;
    logic                  pred_ok_reg, pred_ok_next;
    logic [KEY_W-1:0]      succ_reg, succ_next;
    logic                  succ_ok_reg, succ_ok_next;
    logic [KEY_W-1:0]      sel_reg, sel_next;
    logic                  sel_ok_reg, sel_ok_next;
    logic [KEY_W-1:0]      ans_reg, ans_next;
    status_t               st_reg, st_next;

    logic [COUNT_BITS:0]   seen_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        x_reg       <= x_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        sum_reg     <= sum_next;
        seen_reg    <= seen_next;
        pcnt_reg    <= pcnt_next;
        present_reg <= present_next;
        pred_reg    <= pred_next;
        pred_ok_reg <= pred_ok_next;
        succ_reg    <= succ_next;
        succ_ok_reg <= succ_ok_next;
        sel_reg     <= sel_next;
        sel_ok_reg  <= sel_ok_next;
        ans_reg     <= ans_next;
        st_reg      <= st_next;
    end

    assign seen_sum = {1'b0, seen_reg} + {1'b0, rsp.rcnt};

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        total_next   = total_reg;
        cmd_next     = cmd_reg;
        x_next       = x_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        seen_next    = seen_reg;
        pcnt_next    = pcnt_reg;
        present_next = present_reg;
        pred_next    = pred_reg;
        pred_ok_next = pred_ok_reg;
        succ_next    = succ_reg;
        succ_ok_next = succ_ok_reg;
        sel_next     = sel_reg;
        sel_ok_next  = sel_ok_reg;
        ans_next     = ans_reg;
        st_next      = st_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        req.raddr    = idx_reg[ADDR_W-1:0];
        req.wen_key  = 1'b0;
        req.wen_cnt  = 1'b0;
        req.waddr    = idx_reg[ADDR_W-1:0];
        req.wkey     = rsp.rkey;
        req.wcnt     = rsp.rcnt;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next     = in_cmd;
                    x_next       = in_operand;
                    idx_next     = '0;
                    pos_next     = '0;
                    sum_next     = '0;
                    seen_next    = '0;
                    pcnt_next    = '0;
                    present_next = 1'b0;
                    pred_ok_next = 1'b0;
                    succ_ok_next = 1'b0;
                    sel_ok_next  = 1'b0;
                    ans_next     = '0;
                    st_next      = ST_OK;
                    state_next   = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (idx_reg == used_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                if ($signed(rsp.rkey) < $signed(x_reg))
                begin
                    sum_next     = sum_reg + rsp.rcnt;
                    pred_next    = rsp.rkey;
                    pred_ok_next = 1'b1;
                    pos_next     = idx_reg + 1'b1;
                end
                if (rsp.rkey == x_reg)
                begin
                    present_next = 1'b1;
                    pcnt_next    = rsp.rcnt;
                end
                if ($signed(rsp.rkey) > $signed(x_reg) && !succ_ok_reg)
                begin
                    succ_next    = rsp.rkey;
                    succ_ok_next = 1'b1;
                end
                if (!sel_ok_reg && seen_sum >= x_reg[COUNT_BITS:0])
                begin
                    sel_next    = rsp.rkey;
                    sel_ok_next = 1'b1;
                end
                seen_next  = seen_sum[COUNT_BITS-1:0];
                idx_next   = idx_reg + 1'b1;
                state_next = S_SCAN_RD;
            end
            S_DECIDE:
            begin
                state_next = S_RESP;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (total_reg == COUNT_MAX ||
                            (!present_reg && used_reg == USED_W'(CAPACITY)))
                        begin
                            st_next = ST_FULL;
                        end
                        else if (present_reg)
                        begin
                            state_next = S_UPDATE;
                        end
                        else
                        begin
                            idx_next   = used_reg;
                            state_next = S_SH_RD;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (present_reg)
                        begin
                            if (pcnt_reg > COUNT_BITS'(1))
                            begin
                                state_next = S_UPDATE;
                            end
                            else
                            begin
                                idx_next   = pos_reg;
                                state_next = S_SH_RD;
                            end
                        end
                    end
                    CMD_RANK:
                    begin
                        ans_next = KEY_W'(sum_reg + COUNT_BITS'(present_reg));
                    end
                    CMD_SELECT:
                    begin
                        if ($signed(x_reg) < $signed(KEY_W'(1)) ||
                            x_reg > KEY_W'(total_reg))
                        begin
                            ans_next = SENTINEL;
                            st_next  = ST_NONE;
                        end
                        else
                        begin
                            ans_next = sel_reg;
                        end
                    end
                    CMD_PRED:
                    begin
                        if (pred_ok_reg)
                        begin
                            ans_next = pred_reg;
                        end
                        else
                        begin
                            ans_next = SENTINEL_NEG;
                            st_next  = ST_NONE;
                        end
                    end
                    CMD_SUCC:
                    begin
                        if (succ_ok_reg)
                        begin
                            ans_next = succ_reg;
                        end
                        else
                        begin
                            ans_next = SENTINEL;
                            st_next  = ST_NONE;
                        end
                    end
                    default:
                    begin
                        ans_next = '0;
                    end
                endcase
            end
            S_SH_RD:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    req.raddr = ADDR_W'(idx_reg - 1'b1);
                    if (idx_reg == pos_reg)
                    begin
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        state_next = S_SH_WR;
                    end
                end
                else
                begin
                    req.raddr = ADDR_W'(idx_reg + 1'b1);
                    if (idx_reg + 1'b1 >= used_reg)
                    begin
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        state_next = S_SH_WR;
                    end
                end
            end
            S_SH_WR:
            begin
                req.wen_key = 1'b1;
                req.wen_cnt = 1'b1;
                if (cmd_reg == CMD_INSERT)
                begin
                    idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
                state_next = S_SH_RD;
            end
            S_UPDATE:
            begin
                req.waddr  = pos_reg[ADDR_W-1:0];
                state_next = S_RESP;
                if (cmd_reg == CMD_INSERT)
                begin
                    total_next  = total_reg + 1'b1;
                    req.wen_cnt = 1'b1;
                    if (present_reg)
                    begin
                        req.wcnt = pcnt_reg + 1'b1;
                    end
                    else
                    begin
                        req.wen_key = 1'b1;
                        req.wkey    = x_reg;
                        req.wcnt    = COUNT_BITS'(1);
                        used_next   = used_reg + 1'b1;
                    end
                end
                else
                begin
                    total_next = total_reg - 1'b1;
                    if (pcnt_reg > COUNT_BITS'(1))
                    begin
                        req.wen_cnt = 1'b1;
                        req.wcnt    = pcnt_reg - 1'b1;
                    end
                    else
                    begin
                        used_next = used_reg - 1'b1;
                    end
                end
            end
            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_answer = ans_reg;
    assign res_status = st_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(CAPACITY))
        else $error("distinct count beyond capacity");

    a_total_covers_used: assert property (@(posedge clk) disable iff (!rst_n)
        KEY_W'(used_reg) <= KEY_W'(total_reg))
        else $error("fewer elements than distinct keys");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |->
            (used_reg == $past(used_reg) + 1'b1 || used_reg + 1'b1 == $past(used_reg)))
        else $error("distinct count jumped");

    a_update_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SH_WR) |-> (cmd_reg == CMD_INSERT || cmd_reg == CMD_REMOVE))
        else $error("shift on a query command");

endmodule

### rtl/ordered_multiset_rank_select_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_multiset_rank_select_unit
// Ordered multiset of signed keys with insert, remove, rank, select, pred, succ.
// ----------------------------------------------------------------------------
// Every command first scans all N distinct keys held, in a linear pass
// through the key/count memory (one write, one registered read port);
// shifting inserts and removes then read and write each moved entry in turn.
// Throughput: one command at a time; the next is taken while a result waits.
// Reset clears the entry and element counts at once; no clearing pass.
module ordered_multiset_rank_select_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] answer
    output logic [1:0]  m_tuser    // [1:0] status
);
    import omrs_pkg::*;

    mem_req_t         req;
    mem_rsp_t         rsp;
    logic             res_valid;
    logic             res_ready;
    logic [KEY_W-1:0] res_answer;
    status_t          res_status;

    logic             ov_reg, ov_next;
    logic [KEY_W-1:0] ans_out_reg;
    status_t          st_out_reg;

    omrs_store u_store (
        .clk (clk),
        .req (req),
        .rsp (rsp)
    );

    omrs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_operand (s_tdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_answer (res_answer),
        .res_status (res_status),
        .req        (req),
        .rsp        (rsp)
    );

    assign res_ready = !ov_reg || m_tready;

    always_comb
    begin
        ov_next = ov_reg;
        if (res_valid && res_ready)
        begin
            ov_next = 1'b1;
        end
        else if (m_tready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            ans_out_reg <= res_answer;
            st_out_reg  <= res_status;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = ans_out_reg;
    assign m_tuser  = st_out_reg;

endmodule
